// ===== design/rss_pkg.sv =====
// Shared types and constants for the running sample statistics block.
// No dependencies; used by every module under design/.
`timescale 1ns / 1ps
package rss_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int CNT_W     = 32;
  localparam int SUM_W     = 56;
  localparam int SUMSQ_W   = 64;
  localparam int PERIOD_W  = 31;
  localparam int TIMER_W   = 32;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 31'd900000000;  // 15 minutes of 1 us ticks

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  // Accumulator snapshot handed from front end to back end.
  typedef struct packed {
    logic [CNT_W-1:0]    cnt;
    logic [SUM_W-1:0]    sum;
    logic [SUMSQ_W-1:0]  sumsq;
    logic [SAMPLE_W-1:0] min_v;
    logic [SAMPLE_W-1:0] max_v;
    logic                report;
    logic                overflow;
  } snap_t;

  // Queue status seen by the back end.
  typedef struct packed {
    logic  empty;
    snap_t head;
  } q_stat_t;

endpackage

// ===== design/rss_front.sv =====
// Front end: accepts samples and ticks, updates accumulators, min/max and timer.
// Depends on rss_pkg; feeds rss_queue with one snapshot per sample.
`timescale 1ns / 1ps
module rss_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic                          in_func,
  input  logic [23:0]                   in_sample,
  input  logic                          cfg_we,
  input  logic [30:0]                   cfg_wdata,
  input  logic                          q_full,
  output logic                          full,
  output logic                          q_push,
  output rss_pkg::snap_t                q_data
);
  import rss_pkg::*;

  logic [PERIOD_W-1:0] period_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SUMSQ_W-1:0]  sumsq_r, sumsq_nxt;
  logic [SAMPLE_W-1:0] min_r, min_nxt, max_r, max_nxt;
  logic [TIMER_W-1:0]  timer_r, timer_nxt;
  logic                ovf_r, ovf_nxt;
  logic                report;
  logic                accept;
  logic [SUM_W:0]      sum_ext;
  logic [SUMSQ_W:0]    sumsq_ext;
  logic [2*SAMPLE_W-1:0] sq;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_push = accept && (in_func == FUNC_SAMPLE);

  always_comb begin
    sq        = in_sample * in_sample;
    sum_ext   = {1'b0, sum_r} + {{(SUM_W+1-SAMPLE_W){1'b0}}, in_sample};
    sumsq_ext = {1'b0, sumsq_r} + {{(SUMSQ_W+1-2*SAMPLE_W){1'b0}}, sq};
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    sumsq_nxt = sumsq_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    timer_nxt = timer_r;
    ovf_nxt   = ovf_r;
    report    = 1'b0;
    if (accept) begin
      if (in_func == FUNC_TICK) begin
        if (timer_r != '1) timer_nxt = timer_r + 1'b1;
      end else begin
        if (sum_ext[SUM_W]) begin
          sum_nxt = '1;
          ovf_nxt = 1'b1;
        end else begin
          sum_nxt = sum_ext[SUM_W-1:0];
        end
        if (sumsq_ext[SUMSQ_W]) begin
          sumsq_nxt = '1;
          ovf_nxt   = 1'b1;
        end else begin
          sumsq_nxt = sumsq_ext[SUMSQ_W-1:0];
        end
        // first sample sets both extremes
        if (cnt_r == '0) begin
          min_nxt = in_sample;
          max_nxt = in_sample;
        end else begin
          if (in_sample < min_r) min_nxt = in_sample;
          if (in_sample > max_r) max_nxt = in_sample;
        end
        if (cnt_r == '1) ovf_nxt = 1'b1;
        else cnt_nxt = cnt_r + 1'b1;
        if (period_r != '0 && timer_r > {1'b0, period_r}) begin
          report    = 1'b1;
          timer_nxt = '0;
        end
      end
    end
    q_data = '{cnt: cnt_nxt, sum: sum_nxt, sumsq: sumsq_nxt, min_v: min_nxt,
               max_v: max_nxt, report: report, overflow: ovf_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
      cnt_r    <= '0;
      sum_r    <= '0;
      sumsq_r  <= '0;
      min_r    <= '0;
      max_r    <= '0;
      timer_r  <= '0;
      ovf_r    <= 1'b0;
    end else begin
      if (cfg_we) period_r <= cfg_wdata;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      sumsq_r <= sumsq_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      timer_r <= timer_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

// ===== design/rss_queue.sv =====
// Two-entry snapshot queue between front end and back end.
// Depends on rss_pkg for the snapshot type.
`timescale 1ns / 1ps
module rss_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  rss_pkg::snap_t   wr_data,
  input  logic             rd_en,
  output logic             full,
  output rss_pkg::q_stat_t stat
);
  import rss_pkg::*;

  snap_t       mem_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r;

  assign full       = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);
  assign stat.head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_r <= ~wr_ptr_r;
      if (rd_en) rd_ptr_r <= ~rd_ptr_r;
      if (wr_en && !rd_en) count_r <= count_r + 2'd1;
      else if (rd_en && !wr_en) count_r <= count_r - 2'd1;
    end
  end

endmodule

// ===== design/rss_back.sv =====
// Back end: serial multiplies, mean divide, variance divide and square root.
// Depends on rss_pkg; drains rss_queue and holds one finished result.
`timescale 1ns / 1ps
module rss_back (
  input  logic             clk,
  input  logic             rst_n,
  input  rss_pkg::q_stat_t q_stat,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output logic [31:0]      out_sample_count,
  output logic [23:0]      out_min_value,
  output logic [23:0]      out_max_value,
  output logic [31:0]      out_mean_q8,
  output logic [31:0]      out_stdev_q8,
  output logic             out_report,
  output logic             out_overflow
);
  import rss_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_SUB, S_DIV, S_SQRT, S_DONE} state_t;

  state_t        state_r;
  logic [6:0]    step_r;
  snap_t         snap_r;
  logic [63:0]   dsq_r;
  logic [95:0]   acc_a_r, md_a_r;
  logic [31:0]   mr_a_r;
  logic [111:0]  acc_b_r, md_b_r;
  logic [55:0]   mr_b_r;
  logic [63:0]   mq_r;
  logic [32:0]   mrem_r;
  logic [127:0]  num_r, root_r, bit_r;
  logic [63:0]   rem_r;
  logic [31:0]   mean_r, sd_r;
  logic          out_valid_r;

  logic [32:0]   mrem_sh;
  logic          mge;
  logic [64:0]   r65;
  logic          dge;
  logic [127:0]  trial;
  logic          sge;
  logic [127:0]  root_nxt;
  logic [111:0]  acc_a_ext;
  logic          load_out;

  assign empty    = !out_valid_r;
  assign q_pop    = (state_r == S_IDLE) && !q_stat.empty;
  assign load_out = (state_r == S_DONE) && (!out_valid_r || pop);

  always_comb begin
    mrem_sh   = {mrem_r[31:0], mq_r[63]};
    mge       = mrem_sh >= {1'b0, snap_r.cnt};
    r65       = {rem_r, num_r[127]};
    dge       = r65 >= {1'b0, dsq_r};
    trial     = root_r + bit_r;
    sge       = num_r >= trial;
    root_nxt  = sge ? ((root_r >> 1) + bit_r) : (root_r >> 1);
    acc_a_ext = {16'b0, acc_a_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      if (load_out) out_valid_r <= 1'b1;
      else if (pop) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (!q_stat.empty) begin
            snap_r  <= q_stat.head;
            dsq_r   <= q_stat.head.cnt * q_stat.head.cnt;
            acc_a_r <= '0;
            md_a_r  <= {32'b0, q_stat.head.sumsq};
            mr_a_r  <= q_stat.head.cnt;
            acc_b_r <= '0;
            md_b_r  <= {56'b0, q_stat.head.sum};
            mr_b_r  <= q_stat.head.sum;
            mq_r    <= {q_stat.head.sum, 8'b0};
            mrem_r  <= '0;
            step_r  <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          // cnt*sumsq and sum*sum by shift-add, mean by restoring divide
          if (mr_a_r[0]) acc_a_r <= acc_a_r + md_a_r;
          md_a_r <= md_a_r << 1;
          mr_a_r <= mr_a_r >> 1;
          if (mr_b_r[0]) acc_b_r <= acc_b_r + md_b_r;
          md_b_r <= md_b_r << 1;
          mr_b_r <= mr_b_r >> 1;
          mrem_r <= mge ? (mrem_sh - {1'b0, snap_r.cnt}) : mrem_sh;
          mq_r   <= {mq_r[62:0], mge};
          step_r <= step_r + 7'd1;
          if (step_r == 7'd63) state_r <= S_SUB;
        end
        S_SUB: begin
          mean_r <= (mq_r[63:32] != '0) ? '1 : mq_r[31:0];
          step_r <= '0;
          rem_r  <= '0;
          // negative or zero variance clamps to zero
          if (acc_a_ext <= acc_b_r) begin
            sd_r    <= '0;
            state_r <= S_DONE;
          end else begin
            num_r   <= {acc_a_ext - acc_b_r, 16'b0};
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r  <= dge ? 64'(r65 - {1'b0, dsq_r}) : r65[63:0];
          num_r  <= {num_r[126:0], dge};
          step_r <= step_r + 7'd1;
          if (step_r == 7'd127) begin
            root_r  <= '0;
            bit_r   <= 128'b1 << 126;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sge) num_r <= num_r - trial;
          root_r <= root_nxt;
          bit_r  <= bit_r >> 2;
          step_r <= step_r + 7'd1;
          if (step_r == 7'd63) begin
            sd_r    <= (root_nxt[127:32] != '0) ? '1 : root_nxt[31:0];
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sample_count <= snap_r.cnt;
      out_min_value    <= snap_r.min_v;
      out_max_value    <= snap_r.max_v;
      out_mean_q8      <= mean_r;
      out_stdev_q8     <= sd_r;
      out_report       <= snap_r.report;
      out_overflow     <= snap_r.overflow;
    end
  end

endmodule

// ===== design/running_sample_statistics.sv =====
// Top level of the running sample statistics block.
// Depends on rss_pkg, rss_front, rss_queue and rss_back.
//
//  channel  | handshake        | payload
//  ---------+------------------+------------------------------------------------
//  input    | push / full      | in_func, in_sample
//  result   | pop / empty      | out_sample_count, out_min_value, out_max_value,
//           |                  | out_mean_q8, out_stdev_q8, out_report, out_overflow
//  config   | cfg_we           | cfg_wdata (report period, 31 bits)
//
// Ticks and samples are accepted one per cycle while the two-entry snapshot
// queue has room; a tick gives no result. The back end handles one sample at
// a time: it takes the sample, forms the shift-add products and mean divide,
// subtracts, runs the bit-serial variance divide and the square root, and
// loads the result; a sample with no spread skips divide and root.
// Reset (rst_n low, synchronous) clears all accumulators and sets the period
// to 900000000 ticks. A stalled result holds the back end in its done step;
// the queue keeps the front end going.
`timescale 1ns / 1ps
module running_sample_statistics (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_func,
  input  logic [23:0] in_sample,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_sample_count,
  output logic [23:0] out_min_value,
  output logic [23:0] out_max_value,
  output logic [31:0] out_mean_q8,
  output logic [31:0] out_stdev_q8,
  output logic        out_report,
  output logic        out_overflow,
  input  logic        cfg_we,
  input  logic [30:0] cfg_wdata
);
  import rss_pkg::*;

  snap_t   q_data;
  logic    q_push, q_full, q_pop;
  q_stat_t q_stat;

  // front end: accumulators, extremes, tick timer, report decision
  rss_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_func   (in_func),
    .in_sample (in_sample),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .full      (full),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  // snapshot queue decouples the cheap front from the slow back
  rss_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_data),
    .rd_en   (q_pop),
    .full    (q_full),
    .stat    (q_stat)
  );

  // back end: mean, variance and deviation, one request at a time
  rss_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .q_pop            (q_pop),
    .pop              (pop),
    .empty            (empty),
    .out_sample_count (out_sample_count),
    .out_min_value    (out_min_value),
    .out_max_value    (out_max_value),
    .out_mean_q8      (out_mean_q8),
    .out_stdev_q8     (out_stdev_q8),
    .out_report       (out_report),
    .out_overflow     (out_overflow)
  );

`ifndef SYNTH
  // extremes of a shown result are ordered
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_min_value <= out_max_value)
    else $error("min above max");

  // a single sample has no spread
  a_one_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_sample_count == 32'd1) |->
      (out_stdev_q8 == 32'd0 && out_min_value == out_max_value))
    else $error("one sample with nonzero spread");

  // queue can never be both full and empty
  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_stat.empty))
    else $error("queue full and empty");

  // back end never takes from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");
`endif

endmodule
